### sv/sacn_pkg.sv
// ----------------------------------------------------------------------------
// sacn_pkg
// Shared types, geometry constants and codes for the set-associative
// tag cache with not-recently-used replacement.
// ----------------------------------------------------------------------------
package sacn_pkg;

  // geometry
  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 48;
  localparam int TAG_BITS  = 40;
  localparam int CNT_BITS  = 40;
  localparam int SET_BITS  = $clog2(MAX_SETS);
  localparam int WAY_BITS  = $clog2(MAX_WAYS);

  // configuration port
  localparam int CFG_BITS     = 4;
  localparam int CFG_IDX_BITS = 2;

  // clamp limits for the geometry registers
  localparam int MIN_OFFSET = 6;
  localparam int MIN_INDEX  = 2;

  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [TAG_BITS-1:0]     tag_t;
  typedef logic [SET_BITS-1:0]     set_t;
  typedef logic [WAY_BITS-1:0]     way_t;
  typedef logic [WAY_BITS:0]       way_cnt_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [1:0]              kind_t;
  typedef logic [7:0]              byte_t;
  typedef logic [CFG_BITS-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_OFFSET_BITS = 2'd0;
  localparam cfg_idx_t REG_INDEX_BITS  = 2'd1;
  localparam cfg_idx_t REG_WAYS_USED   = 2'd2;

  // access kinds
  localparam kind_t HOST_RD = 2'd0;
  localparam kind_t HOST_WR = 2'd1;

  // reset values of the geometry registers
  localparam cfg_data_t RST_OFFSET_BITS = 4'd6;
  localparam cfg_data_t RST_INDEX_BITS  = 4'd8;
  localparam cfg_data_t RST_WAYS_USED   = 4'd8;

  // one set as held in the row memory
  typedef struct packed {
    tag_t [MAX_WAYS-1:0] tags;
    logic [MAX_WAYS-1:0] valid;
    logic [MAX_WAYS-1:0] refb;
  } set_row_t;

  // lookup outcome handed back to the control
  typedef struct packed {
    logic hit;
    way_t way;
  } lookup_t;

endpackage

### sv/sacn_if.sv
// ----------------------------------------------------------------------------
// sacn_req_if / sacn_rsp_if
// Valid/ready channels for access words going in and result words coming
// out of the cache.
// ----------------------------------------------------------------------------
interface sacn_req_if;
  import sacn_pkg::*;

  logic  valid;
  logic  ready;
  addr_t address;
  kind_t req_type;
  byte_t byte_count;
  byte_t proc_id;

  modport source (output valid, address, req_type, byte_count, proc_id, input ready);
  modport sink   (input valid, address, req_type, byte_count, proc_id, output ready);
endinterface

interface sacn_rsp_if;
  import sacn_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  way_t  way_used;
  addr_t miss_address;
  kind_t miss_kind;
  byte_t miss_bytes;
  byte_t miss_proc;
  cnt_t  total_hits;
  cnt_t  total_misses;
  cnt_t  read_misses;
  cnt_t  write_misses;

  modport source (
    output valid, hit, way_used, miss_address, miss_kind, miss_bytes, miss_proc,
           total_hits, total_misses, read_misses, write_misses,
    input  ready
  );
  modport sink (
    input  valid, hit, way_used, miss_address, miss_kind, miss_bytes, miss_proc,
           total_hits, total_misses, read_misses, write_misses,
    output ready
  );
endinterface

### sv/set_assoc_cache_nru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_nru
// Tag-only set-associative cache with NRU replacement and saturating
// hit/miss counters; one set row per memory word.
// ----------------------------------------------------------------------------
// result: the access and its set row are registered on accept; the result word
//   is registered when the lookup retires, held while the previous word is unread
// flow: one access at a time; its set row is read, then written back when it retires
// reset: synchronous; clears the per-row valid flags and counters and loads the
//   geometry registers (6, 8, 8) directly, no clearing pass
// ----------------------------------------------------------------------------
module set_assoc_cache_nru (
  input  logic                 clk,
  input  logic                 rst_n,
  sacn_req_if.sink             in_req,
  sacn_rsp_if.source           out_rsp,
  input  logic                 cfg_we,
  input  sacn_pkg::cfg_idx_t   cfg_index,
  input  sacn_pkg::cfg_data_t  cfg_wdata
);
  import sacn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  localparam cnt_t CNT_MAX = '1;

  state_t    state_r, state_nxt;
  cfg_data_t offset_bits_r, index_bits_r, ways_used_r;

  // clamped geometry
  logic [4:0] off_eff;
  logic [4:0] idx_eff;
  way_cnt_t   nways;
  addr_t      addr_sh;
  addr_t      addr_tag_sh;
  set_t       set_mask;
  set_t       set_in;
  tag_t       tag_in;

  // request held for the lookup
  set_t  set_r;
  tag_t  tag_r;
  addr_t addr_r;
  kind_t kind_r;
  byte_t bytes_r;
  byte_t proc_r;

  // row memory and row valid flags
  set_row_t             row_mem [MAX_SETS];
  logic [MAX_SETS-1:0]  row_vld_r;
  set_row_t             rd_row_r;
  logic                 rd_vld_r;
  set_row_t             cur_row;
  set_row_t             new_row;
  lookup_t              lk;

  // counters
  cnt_t hit_cnt_r, miss_cnt_r, rd_miss_cnt_r, wr_miss_cnt_r;

  // result register
  logic  out_valid_r;
  logic  hit_r;
  way_t  way_r;
  addr_t miss_addr_r;
  kind_t miss_kind_r;
  byte_t miss_bytes_r;
  byte_t miss_proc_r;

  logic accept;
  logic done;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == CNT_MAX) ? CNT_MAX : c + cnt_t'(1);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= RST_OFFSET_BITS;
      index_bits_r  <= RST_INDEX_BITS;
      ways_used_r   <= RST_WAYS_USED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        REG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
        REG_WAYS_USED:   ways_used_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // geometry clamps
  always_comb begin
    off_eff = (offset_bits_r < cfg_data_t'(MIN_OFFSET)) ? 5'(MIN_OFFSET)
                                                       : 5'(offset_bits_r);
    if (index_bits_r < cfg_data_t'(MIN_INDEX)) begin
      idx_eff = 5'(MIN_INDEX);
    end else if (index_bits_r > cfg_data_t'(SET_BITS)) begin
      idx_eff = 5'(SET_BITS);
    end else begin
      idx_eff = 5'(index_bits_r);
    end
    if (ways_used_r == '0) begin
      nways = way_cnt_t'(1);
    end else if (ways_used_r > cfg_data_t'(MAX_WAYS)) begin
      nways = way_cnt_t'(MAX_WAYS);
    end else begin
      nways = way_cnt_t'(ways_used_r);
    end
  end

  // address split
  assign addr_sh     = in_req.address >> off_eff;
  assign addr_tag_sh = in_req.address >> (off_eff + idx_eff);
  assign set_mask    = ~(set_t'('1) << idx_eff);
  assign set_in      = addr_sh[SET_BITS-1:0] & set_mask;
  assign tag_in      = addr_tag_sh[TAG_BITS-1:0];

  // handshake
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign done         = (state_r == S_LOOK) && (!out_valid_r || out_rsp.ready);

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LOOK;
      S_LOOK:  if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      set_r   <= set_in;
      tag_r   <= tag_in;
      addr_r  <= in_req.address;
      kind_r  <= in_req.req_type;
      bytes_r <= in_req.byte_count;
      proc_r  <= in_req.proc_id;
    end
  end

  // row memory: read on accept, write back when the lookup retires
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= row_mem[set_in];
    end
    if (done) begin
      row_mem[set_r] <= new_row;
    end
  end

  // row valid flags; a row never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (accept) rd_vld_r <= row_vld_r[set_in];
      if (done) row_vld_r[set_r] <= 1'b1;
    end
  end

  assign cur_row = rd_vld_r ? rd_row_r : '0;

  sacn_lookup u_lookup (
    .row     (cur_row),
    .tag     (tag_r),
    .nways   (nways),
    .res     (lk),
    .new_row (new_row)
  );

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      rd_miss_cnt_r <= '0;
      wr_miss_cnt_r <= '0;
    end else if (done) begin
      if (lk.hit) begin
        hit_cnt_r <= sat_inc(hit_cnt_r);
      end else begin
        miss_cnt_r <= sat_inc(miss_cnt_r);
        if (kind_r == HOST_RD) rd_miss_cnt_r <= sat_inc(rd_miss_cnt_r);
        if (kind_r == HOST_WR) wr_miss_cnt_r <= sat_inc(wr_miss_cnt_r);
      end
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word payload; forwarded fields are zero on a hit
  always_ff @(posedge clk) begin
    if (done) begin
      hit_r        <= lk.hit;
      way_r        <= lk.way;
      miss_addr_r  <= lk.hit ? '0 : addr_r;
      miss_kind_r  <= lk.hit ? '0 : kind_r;
      miss_bytes_r <= lk.hit ? '0 : bytes_r;
      miss_proc_r  <= lk.hit ? '0 : proc_r;
    end
  end

  // counters change only when a new word is loaded, so they track it
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.hit          = hit_r;
  assign out_rsp.way_used     = way_r;
  assign out_rsp.miss_address = miss_addr_r;
  assign out_rsp.miss_kind    = miss_kind_r;
  assign out_rsp.miss_bytes   = miss_bytes_r;
  assign out_rsp.miss_proc    = miss_proc_r;
  assign out_rsp.total_hits   = hit_cnt_r;
  assign out_rsp.total_misses = miss_cnt_r;
  assign out_rsp.read_misses  = rd_miss_cnt_r;
  assign out_rsp.write_misses = wr_miss_cnt_r;

endmodule

### sv/sacn_lookup.sv
// ----------------------------------------------------------------------------
// sacn_lookup
// Tag match and victim choice over one set row; produces the row to write
// back with updated tags, valid and reference bits.
// ----------------------------------------------------------------------------
module sacn_lookup (
  input  sacn_pkg::set_row_t row,
  input  sacn_pkg::tag_t     tag,
  input  sacn_pkg::way_cnt_t nways,
  output sacn_pkg::lookup_t  res,
  output sacn_pkg::set_row_t new_row
);
  import sacn_pkg::*;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic [MAX_WAYS-1:0] nref_vec;
  way_t                hit_way;
  way_t                inv_way;
  way_t                nref_way;
  way_t                vic_way;
  logic                any_hit;
  logic                any_inv;
  logic                any_nref;

  // lowest set bit of a way vector
  function automatic way_t first_way(input logic [MAX_WAYS-1:0] vec);
    way_t r;
    r = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (vec[w]) r = way_t'(w);
    end
    return r;
  endfunction

  // per-way candidates
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = way_cnt_t'(w) < nways;
      hit_vec[w]  = in_use[w] && row.valid[w] && (row.tags[w] == tag);
      inv_vec[w]  = in_use[w] && !row.valid[w];
      nref_vec[w] = in_use[w] && !row.refb[w];
    end
  end

  assign any_hit  = |hit_vec;
  assign any_inv  = |inv_vec;
  assign any_nref = |nref_vec;
  assign hit_way  = first_way(hit_vec);
  assign inv_way  = first_way(inv_vec);
  assign nref_way = first_way(nref_vec);

  // victim: first free way, else first unreferenced way, else way 0
  always_comb begin
    priority if (any_inv) begin
      vic_way = inv_way;
    end else if (any_nref) begin
      vic_way = nref_way;
    end else begin
      vic_way = '0;
    end
  end

  assign res.hit = any_hit;
  assign res.way = any_hit ? hit_way : vic_way;

  // updated row
  always_comb begin
    new_row = row;
    if (any_hit) begin
      new_row.refb[hit_way] = 1'b1;
    end else begin
      if (!any_inv && !any_nref) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          if (in_use[w]) new_row.refb[w] = 1'b0;
        end
      end
      new_row.tags[vic_way]  = tag;
      new_row.valid[vic_way] = 1'b1;
      new_row.refb[vic_way]  = 1'b1;
    end
  end

endmodule

### tb/tb_set_assoc_cache_nru.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_nru
// Self-checking bench for the set-associative tag cache with NRU
// replacement. A local model of the tag, valid and reference stores and
// the saturating counters predicts every result word from the access
// words as they are accepted. Directed accesses exercise fill order,
// the reference-bit clear and hits. Random phases then run under several
// cache geometries, including out-of-range register values, with random
// idle gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_nru;
  import sacn_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int STORE_DEPTH  = MAX_SETS * MAX_WAYS;

  // request kinds without a name in the package, and the spare register index
  localparam kind_t    KIND_OTHER = 2'd2;
  localparam kind_t    KIND_SPARE = 2'd3;
  localparam cfg_idx_t REG_SPARE  = 2'd3;

  typedef struct packed {
    addr_t address;
    kind_t req_type;
    byte_t byte_count;
    byte_t proc_id;
  } access_t;

  typedef struct packed {
    logic  hit;
    way_t  way_used;
    addr_t miss_address;
    kind_t miss_kind;
    byte_t miss_bytes;
    byte_t miss_proc;
    cnt_t  total_hits;
    cnt_t  total_misses;
    cnt_t  read_misses;
    cnt_t  write_misses;
  } result_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  sacn_req_if req_bus ();
  sacn_rsp_if rsp_bus ();

  set_assoc_cache_nru dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_bus),
    .out_rsp   (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state of the cache
  bit [TAG_BITS-1:0] tag_mem   [STORE_DEPTH];
  bit                valid_mem [STORE_DEPTH];
  bit                ref_mem   [STORE_DEPTH];
  cnt_t      hit_total  = '0;
  cnt_t      miss_total = '0;
  cnt_t      rd_miss    = '0;
  cnt_t      wr_miss    = '0;
  cfg_data_t cur_offset = RST_OFFSET_BITS;
  cfg_data_t cur_index  = RST_INDEX_BITS;
  cfg_data_t cur_ways   = RST_WAYS_USED;

  // stimulus and expectation stores
  access_t     pending_accesses [$];
  result_t     expected_results [$];
  result_t     expected_word;
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned word_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  int unsigned send_idle_pct  = 30;
  int unsigned recv_stall_pct = 30;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // effective geometry after clamping
  function automatic int unsigned eff_offset();
    return (cur_offset < MIN_OFFSET) ? MIN_OFFSET : cur_offset;
  endfunction

  function automatic int unsigned eff_index();
    if (cur_index < MIN_INDEX) return MIN_INDEX;
    if (cur_index > SET_BITS) return SET_BITS;
    return cur_index;
  endfunction

  function automatic int unsigned eff_ways();
    if (cur_ways == 0) return 1;
    if (cur_ways > MAX_WAYS) return MAX_WAYS;
    return cur_ways;
  endfunction

  function automatic cnt_t bump(cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // lookup, replacement and counters for one access
  function automatic result_t lookup_and_fill(access_t acc);
    int unsigned off, idx, nways, base, way;
    int          w;
    tag_t        tag;
    bit          hit, placed;
    result_t     res;
    off    = eff_offset();
    idx    = eff_index();
    nways  = eff_ways();
    base   = int'((acc.address >> off) & ((addr_t'(1) << idx) - addr_t'(1))) * MAX_WAYS;
    tag    = tag_t'(acc.address >> (off + idx));
    hit    = 1'b0;
    placed = 1'b0;
    way    = 0;
    for (w = 0; w < nways; w++) begin
      if (!hit && valid_mem[base+w] && tag_mem[base+w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    end
    if (hit) begin
      ref_mem[base+way] = 1'b1;
      hit_total = bump(hit_total);
    end else begin
      miss_total = bump(miss_total);
      if (acc.req_type == HOST_RD) rd_miss = bump(rd_miss);
      if (acc.req_type == HOST_WR) wr_miss = bump(wr_miss);
      // first invalid way, then first way not recently used
      for (w = 0; w < nways; w++) begin
        if (!placed && !valid_mem[base+w]) begin
          way = w;
          placed = 1'b1;
        end
      end
      for (w = 0; w < nways; w++) begin
        if (!placed && !ref_mem[base+w]) begin
          way = w;
          placed = 1'b1;
        end
      end
      // all referenced: clear the set and take way 0
      if (!placed) begin
        for (w = 0; w < nways; w++) ref_mem[base+w] = 1'b0;
        way = 0;
      end
      tag_mem[base+way]   = tag;
      valid_mem[base+way] = 1'b1;
      ref_mem[base+way]   = 1'b1;
    end
    res = '0;
    res.hit      = hit;
    res.way_used = way_t'(way);
    if (!hit) begin
      res.miss_address = acc.address;
      res.miss_kind    = acc.req_type;
      res.miss_bytes   = acc.byte_count;
      res.miss_proc    = acc.proc_id;
    end
    res.total_hits   = hit_total;
    res.total_misses = miss_total;
    res.read_misses  = rd_miss;
    res.write_misses = wr_miss;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic addr_t make_addr(int unsigned tag, int unsigned set,
                                      int unsigned byte_off);
    int unsigned off;
    off = eff_offset();
    return (addr_t'(tag) << (off + eff_index())) | (addr_t'(set) << off) |
           (addr_t'(byte_off) & ((addr_t'(1) << off) - addr_t'(1)));
  endfunction

  task automatic queue_access(addr_t a, kind_t k, byte_t b, byte_t p);
    access_t acc;
    acc.address    = a;
    acc.req_type   = k;
    acc.byte_count = b;
    acc.proc_id    = p;
    pending_accesses.push_back(acc);
    queued_count++;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("word %0d: %s mismatch, got %0h expected %0h", word_count, what, got, want);
  endtask

  // wait until every access is accepted and every word has come back
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the three geometry registers back to back, optionally the spare one
  task automatic set_geometry(cfg_data_t off, cfg_data_t idx, cfg_data_t ways,
                              bit touch_spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= REG_INDEX_BITS;
    cfg_wdata <= idx;
    @(posedge clk);
    cfg_index <= REG_WAYS_USED;
    cfg_wdata <= ways;
    @(posedge clk);
    if (touch_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= cfg_data_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_offset = off;
    cur_index  = idx;
    cur_ways   = ways;
  endtask

  // random accesses: mostly a small tag pool over a few sets, some noise
  task automatic queue_random(int unsigned count);
    int unsigned n, set, tag, idx;
    for (n = 0; n < count; n++) begin
      idx = eff_index();
      if ($urandom_range(0, 99) < 20) begin
        queue_access(addr_t'({$urandom, $urandom}), kind_t'($urandom),
                     byte_t'($urandom), byte_t'($urandom));
      end else begin
        set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << idx) - 1)
                                          : $urandom_range(0, 3);
        tag = $urandom_range(0, eff_ways() + 2);
        queue_access(make_addr(tag, set, $urandom), kind_t'($urandom),
                     byte_t'($urandom), byte_t'($urandom));
      end
    end
  endtask

  // access driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid      <= 1'b0;
      req_bus.address    <= '0;
      req_bus.req_type   <= HOST_RD;
      req_bus.byte_count <= '0;
      req_bus.proc_id    <= '0;
      send_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_results.push_back(lookup_and_fill({req_bus.address, req_bus.req_type,
                                                    req_bus.byte_count, req_bus.proc_id}));
        accepted_count++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_bus.valid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          req_bus.address    <= pending_accesses[0].address;
          req_bus.req_type   <= pending_accesses[0].req_type;
          req_bus.byte_count <= pending_accesses[0].byte_count;
          req_bus.proc_id    <= pending_accesses[0].proc_id;
          req_bus.valid      <= 1'b1;
          void'(pending_accesses.pop_front());
          send_gap = pick_gap(send_idle_pct);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", {63'd0, rsp_bus.hit}, 64'd0);
        end else begin
          expected_word = expected_results.pop_front();
          if (rsp_bus.hit !== expected_word.hit)
            report_mismatch("hit", rsp_bus.hit, expected_word.hit);
          if (rsp_bus.way_used !== expected_word.way_used)
            report_mismatch("way_used", rsp_bus.way_used, expected_word.way_used);
          if (rsp_bus.miss_address !== expected_word.miss_address)
            report_mismatch("miss_address", rsp_bus.miss_address, expected_word.miss_address);
          if (rsp_bus.miss_kind !== expected_word.miss_kind)
            report_mismatch("miss_kind", rsp_bus.miss_kind, expected_word.miss_kind);
          if (rsp_bus.miss_bytes !== expected_word.miss_bytes)
            report_mismatch("miss_bytes", rsp_bus.miss_bytes, expected_word.miss_bytes);
          if (rsp_bus.miss_proc !== expected_word.miss_proc)
            report_mismatch("miss_proc", rsp_bus.miss_proc, expected_word.miss_proc);
          if (rsp_bus.total_hits !== expected_word.total_hits)
            report_mismatch("total_hits", rsp_bus.total_hits, expected_word.total_hits);
          if (rsp_bus.total_misses !== expected_word.total_misses)
            report_mismatch("total_misses", rsp_bus.total_misses, expected_word.total_misses);
          if (rsp_bus.read_misses !== expected_word.read_misses)
            report_mismatch("read_misses", rsp_bus.read_misses, expected_word.read_misses);
          if (rsp_bus.write_misses !== expected_word.write_misses)
            report_mismatch("write_misses", rsp_bus.write_misses, expected_word.write_misses);
        end
        word_count++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        recv_stall = pick_gap(recv_stall_pct);
        rsp_bus.ready <= (recv_stall == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // reset, directed accesses, then random phases over several geometries
  initial begin
    int unsigned k;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_OFFSET_BITS;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // same block at both offset extremes, all-ones address, odd kinds
    queue_access(make_addr(0, 0, 0), HOST_RD, 8'h00, 8'h00);
    queue_access(make_addr(0, 0, 63), HOST_WR, 8'hff, 8'hff);
    queue_access('1, KIND_SPARE, 8'hff, 8'hff);
    queue_access('1, KIND_OTHER, 8'h01, 8'h02);
    // fill every way of one set in order
    for (k = 1; k <= MAX_WAYS; k++)
      queue_access(make_addr(k, 1, k), kind_t'(k), byte_t'(k), byte_t'(~k));
    // all referenced: clear and take way 0, then the first unreferenced way
    queue_access(make_addr(9, 1, 0), HOST_RD, 8'h10, 8'h20);
    queue_access(make_addr(10, 1, 0), HOST_WR, 8'h11, 8'h21);
    queue_access(make_addr(3, 1, 5), HOST_RD, 8'h12, 8'h22);
    queue_access(make_addr(11, 1, 0), KIND_OTHER, 8'h13, 8'h23);
    queue_access(make_addr(9, 1, 7), HOST_WR, 8'h14, 8'h24);
    queue_access(48'h8000_0000_0000, HOST_WR, 8'h80, 8'h7f);
    queue_access(make_addr(1, 1, 0), HOST_RD, 8'h55, 8'haa);
    queue_random(90);

    // lowest valid index bits and way count
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(4'd8, 4'd2, 4'd1, 1'b0);
    queue_random(70);

    // below range, clamped up, plus the unused register index
    wait_idle();
    send_idle_pct  = 40;
    recv_stall_pct = 10;
    set_geometry(4'd0, 4'd0, 4'd0, 1'b1);
    queue_random(70);

    // index and way count above range, clamped down
    wait_idle();
    send_idle_pct  = 10;
    recv_stall_pct = 50;
    set_geometry(4'd15, 4'd15, 4'd15, 1'b0);
    queue_random(80);

    wait_idle();
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    set_geometry(4'd7, 4'd4, 4'd3, 1'b0);
    queue_random(80);

    // back to the reset geometry with stale entries from the other shapes
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    set_geometry(RST_OFFSET_BITS, RST_INDEX_BITS, RST_WAYS_USED, 1'b0);
    queue_random(80);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
